// ===== design/srb_pkg.sv =====
// srb_pkg: shared constants, opcodes and sequencer state codes for the
// sequenced replay buffer; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package srb_pkg;

  localparam int DEPTH_DEF        = 32;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int SEQ_BITS         = 64;
  localparam int PORT_PAY_BITS    = 32;
  localparam int LIMIT_BITS       = 6;
  localparam int MAX_RESULTS      = 32;

  localparam logic OPC_APPEND = 1'b0;
  localparam logic OPC_QUERY  = 1'b1;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_TAG  = 14'b00000000000010,
    S_P0R  = 14'b00000000000100,
    S_P0L  = 14'b00000000001000,
    S_BR   = 14'b00000000010000,
    S_BC   = 14'b00000000100000,
    S_BW   = 14'b00000001000000,
    S_LR   = 14'b00000010000000,
    S_LL   = 14'b00000100000000,
    S_CK1  = 14'b00001000000000,
    S_CK2  = 14'b00010000000000,
    S_SR   = 14'b00100000000000,
    S_SC   = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } srb_state_t;

endpackage
`default_nettype wire

// ===== design/srb_ram.sv =====
// srb_ram: generic one-write one-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module srb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/srb_cmp.sv =====
// srb_cmp: shared unsigned magnitude compare unit used by the sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module srb_cmp #(
  parameter int KW = 70
) (
  input  wire logic [KW-1:0] a,
  input  wire logic [KW-1:0] b,
  output logic               gt
);

  assign gt = (a > b);

endmodule
`default_nettype wire

// ===== design/sequenced_replay_buffer_top.sv =====
// sequenced_replay_buffer_top: ring store of sequence-numbered records with
// sorted replay queries; uses srb_pkg, srb_ram and srb_cmp
//
// usage
//   input channel (in_valid/in_ready): opcode append stores seq_number and
//   payload after the newest record, dropping the oldest when full; an
//   append below the newest number marks the store as out of order.
//   opcode query returns, on the output channel (out_valid/out_ready), up to
//   limit records from the first one at or above seq_number, last marking the
//   final transfer, or a single not-found transfer.
//   an append gives no result.
//   a query first sorts the store if it is marked: it tags the records,
//   then runs (count-1) bubble passes, all on the single read and single
//   write port of the record memory.
//   then it does the range check, reads and compares each record scanned,
//   and waits for the receiver on each delivered transfer.
//   in_ready is high only while no item is in progress.
//   reset clears the record count, head pointer and order flag; memory
//   contents are not cleared and need no clearing pass.
//   a stalled receiver holds the output register and the sequencer waits.
`timescale 1ns / 1ps
`default_nettype none
module sequenced_replay_buffer_top
  import srb_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     opcode,
  input  wire logic [SEQ_BITS-1:0]      seq_number,
  input  wire logic [PORT_PAY_BITS-1:0] payload,
  input  wire logic [LIMIT_BITS-1:0]    limit,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          found,
  output logic [SEQ_BITS-1:0]           out_seq_number,
  output logic [PORT_PAY_BITS-1:0]      out_payload,
  output logic                          last,
  output logic                          store_empty,
  output logic [SEQ_BITS-1:0]           lowest_seq,
  output logic [SEQ_BITS-1:0]           highest_seq
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = SEQ_BITS + AW;
  localparam int DW = SEQ_BITS + PAYLOAD_BITS;

  srb_state_t state;

  // control registers
  logic [AW-1:0]         head;
  logic [CW-1:0]         count;
  logic                  ooo;
  logic [SEQ_BITS-1:0]   newest;
  logic [SEQ_BITS-1:0]   q_seq;
  logic [LIMIT_BITS-1:0] q_lim;
  logic [CW-1:0]         j;
  logic [CW-1:0]         npass;
  logic [CW-1:0]         idx;
  logic [LIMIT_BITS-1:0] emitted;
  logic [SEQ_BITS-1:0]   lo;

  // carried record of the bubble pass
  logic [SEQ_BITS-1:0]     cur_seq;
  logic [PAYLOAD_BITS-1:0] cur_pay;
  logic [AW-1:0]           cur_tag;

  // memory ports
  logic          d_we, t_we;
  logic [AW-1:0] d_wa, t_wa, rd_a;
  logic [DW-1:0] d_wd, d_rd;
  logic [AW-1:0] t_wd, t_rd;

  logic [SEQ_BITS-1:0]     rd_seq;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic [63:0]             rd_pay_ext, pay_in_ext;
  logic [PAYLOAD_BITS-1:0] pay_in;

  logic [KW-1:0] cmp_a, cmp_b;
  logic          gt;

  logic [CW-1:0]         cnt_m1;
  logic [AW-1:0]         head_inc, app_slot, scan_slot, tag_val, jm1;
  logic [AW:0]           scan_sum, tag_wrap;
  logic [LIMIT_BITS-1:0] lim_sat, emit_p1;
  logic                  is_empty, scan_last;
  logic [SEQ_BITS-1:0]   lo_rep, hi_rep;

  assign rd_seq     = d_rd[DW-1:PAYLOAD_BITS];
  assign rd_pay     = d_rd[PAYLOAD_BITS-1:0];
  assign rd_pay_ext = 64'(rd_pay);
  assign pay_in_ext = 64'(payload);
  assign pay_in     = pay_in_ext[PAYLOAD_BITS-1:0];

  assign cnt_m1   = count - CW'(1);
  assign is_empty = (count == '0);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
  assign app_slot = (count < CW'(DEPTH)) ? count[AW-1:0] : head;
  assign jm1      = j[AW-1:0] - AW'(1);

  // logical to physical slot: head plus index, wrapped at the depth
  assign scan_sum  = {1'b0, head} + {1'b0, idx[AW-1:0]};
  assign scan_slot = (scan_sum >= (AW+1)'(DEPTH)) ? AW'(scan_sum - (AW+1)'(DEPTH))
                                                 : scan_sum[AW-1:0];

  // tie-break tag: age rank of a physical slot before the sort
  assign tag_wrap = {1'b0, j[AW-1:0]} + (AW+1)'(DEPTH) - {1'b0, head};
  assign tag_val  = (j[AW-1:0] >= head) ? (j[AW-1:0] - head) : tag_wrap[AW-1:0];

  assign lim_sat   = (limit > LIMIT_BITS'(MAX_RESULTS)) ? LIMIT_BITS'(MAX_RESULTS) : limit;
  assign emit_p1   = emitted + LIMIT_BITS'(1);
  assign scan_last = (emit_p1 == q_lim) || (idx == cnt_m1);
  assign lo_rep    = is_empty ? '1 : lo;
  assign hi_rep    = is_empty ? '1 : newest;

  assign in_ready = (state == S_IDLE);

  srb_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_rec_ram (
    .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(rd_a), .rdata(d_rd)
  );

  srb_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_tag_ram (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(rd_a), .rdata(t_rd)
  );

  srb_cmp #(.KW(KW)) u_cmp (.a(cmp_a), .b(cmp_b), .gt(gt));

  // memory port steering
  always_comb begin
    d_we = 1'b0;
    d_wa = '0;
    d_wd = {cur_seq, cur_pay};
    t_we = 1'b0;
    t_wa = '0;
    t_wd = cur_tag;
    rd_a = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && opcode == OPC_APPEND) begin
          d_we = 1'b1;
          d_wa = app_slot;
          d_wd = {seq_number, pay_in};
        end
      end
      S_TAG: begin
        t_we = 1'b1;
        t_wa = j[AW-1:0];
        t_wd = tag_val;
      end
      S_P0R: rd_a = '0;
      S_BR:  rd_a = j[AW-1:0];
      S_BC: begin
        d_we = 1'b1;
        t_we = 1'b1;
        d_wa = jm1;
        t_wa = jm1;
        if (gt) begin
          d_wd = d_rd;
          t_wd = t_rd;
        end
      end
      S_BW: begin
        d_we = 1'b1;
        t_we = 1'b1;
        d_wa = cnt_m1[AW-1:0];
        t_wa = cnt_m1[AW-1:0];
      end
      S_LR: rd_a = head;
      S_SR: rd_a = scan_slot;
      default: ;
    endcase
  end

  // operand selection for the shared compare unit
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state)
      S_IDLE: begin
        cmp_a = {newest, AW'(0)};
        cmp_b = {seq_number, AW'(0)};
      end
      S_BC: begin
        cmp_a = {cur_seq, cur_tag};
        cmp_b = {rd_seq, t_rd};
      end
      S_CK1: begin
        cmp_a = {lo, AW'(0)};
        cmp_b = {q_seq, AW'(0)};
      end
      S_CK2: begin
        cmp_a = {q_seq, AW'(0)};
        cmp_b = {newest, AW'(0)};
      end
      S_SC: begin
        cmp_a = {q_seq, AW'(0)};
        cmp_b = {rd_seq, AW'(0)};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      ooo       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (opcode == OPC_APPEND) begin
              if (!is_empty && gt) begin
                ooo <= 1'b1;
              end
              newest <= seq_number;
              if (count < CW'(DEPTH)) begin
                count <= count + CW'(1);
              end else begin
                head <= head_inc;
              end
            end else begin
              q_seq <= seq_number;
              q_lim <= lim_sat;
              j     <= '0;
              state <= ooo ? S_TAG : S_LR;
            end
          end
        end
        S_TAG: begin
          if (j == cnt_m1) begin
            npass <= '0;
            state <= S_P0R;
          end else begin
            j <= j + CW'(1);
          end
        end
        S_P0R: state <= S_P0L;
        S_P0L: begin
          cur_seq <= rd_seq;
          cur_pay <= rd_pay;
          cur_tag <= t_rd;
          j       <= CW'(1);
          state   <= S_BR;
        end
        S_BR: state <= S_BC;
        S_BC: begin
          if (!gt) begin
            cur_seq <= rd_seq;
            cur_pay <= rd_pay;
            cur_tag <= t_rd;
          end
          if (j == cnt_m1) begin
            state <= S_BW;
          end else begin
            j     <= j + CW'(1);
            state <= S_BR;
          end
        end
        S_BW: begin
          // the carried record is the largest after every pass
          newest <= cur_seq;
          if (npass == count - CW'(2)) begin
            head  <= '0;
            ooo   <= 1'b0;
            state <= S_LR;
          end else begin
            npass <= npass + CW'(1);
            state <= S_P0R;
          end
        end
        S_LR: begin
          if (is_empty) begin
            found          <= 1'b0;
            out_seq_number <= '0;
            out_payload    <= '0;
            last           <= 1'b1;
            store_empty    <= 1'b1;
            lowest_seq     <= '1;
            highest_seq    <= '1;
            out_valid      <= 1'b1;
            state          <= S_OUT;
          end else begin
            state <= S_LL;
          end
        end
        S_LL: begin
          lo    <= rd_seq;
          state <= S_CK1;
        end
        S_CK1, S_CK2: begin
          if (gt || q_lim == '0) begin
            found          <= 1'b0;
            out_seq_number <= '0;
            out_payload    <= '0;
            last           <= 1'b1;
            store_empty    <= 1'b0;
            lowest_seq     <= lo_rep;
            highest_seq    <= hi_rep;
            out_valid      <= 1'b1;
            state          <= S_OUT;
          end else if (state == S_CK1) begin
            state <= S_CK2;
          end else begin
            idx     <= '0;
            emitted <= '0;
            state   <= S_SR;
          end
        end
        S_SR: state <= S_SC;
        S_SC: begin
          if (gt) begin
            // below the query number, keep scanning
            idx   <= idx + CW'(1);
            state <= S_SR;
          end else begin
            found          <= 1'b1;
            out_seq_number <= rd_seq;
            out_payload    <= rd_pay_ext[PORT_PAY_BITS-1:0];
            last           <= scan_last;
            store_empty    <= 1'b0;
            lowest_seq     <= lo_rep;
            highest_seq    <= hi_rep;
            out_valid      <= 1'b1;
            state          <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else begin
              idx     <= idx + CW'(1);
              emitted <= emit_p1;
              state   <= S_SR;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT))
    else $error("output transfer pending outside delivery state");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("record count above depth");

  a_head_full: assert property (@(posedge clk) disable iff (rst)
    (head != '0) |-> (count == CW'(DEPTH)))
    else $error("ring rotated while not full");

  a_sort_clears: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_BW && state == S_LR) |-> (!ooo && head == '0))
    else $error("sort finished without clearing order flag");

endmodule
`default_nettype wire

// ===== tb/srb_checker.sv =====
// srb_checker: watches both channels of the sequenced replay buffer, predicts
// the delivered records and compares them; depends on srb_pkg
`timescale 1ns / 1ps
module srb_checker
  import srb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     opcode,
  input  logic [SEQ_BITS-1:0]      seq_number,
  input  logic [PORT_PAY_BITS-1:0] payload,
  input  logic [LIMIT_BITS-1:0]    limit,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     found,
  input  logic [SEQ_BITS-1:0]      out_seq_number,
  input  logic [PORT_PAY_BITS-1:0] out_payload,
  input  logic                     last,
  input  logic                     store_empty,
  input  logic [SEQ_BITS-1:0]      lowest_seq,
  input  logic [SEQ_BITS-1:0]      highest_seq,
  output int                       fail_count,
  output int                       records_pending,
  output int                       records_seen,
  output int                       queries_seen
);

  typedef struct packed {
    logic                     found;
    logic [SEQ_BITS-1:0]      seq;
    logic [PORT_PAY_BITS-1:0] pay;
    logic                     last;
    logic                     empty;
    logic [SEQ_BITS-1:0]      lo;
    logic [SEQ_BITS-1:0]      hi;
  } replay_rec_t;

  logic [SEQ_BITS-1:0]      seq_mem [DEPTH_DEF];
  logic [PORT_PAY_BITS-1:0] pay_mem [DEPTH_DEF];
  int                       head;
  int                       count;
  bit                       unsorted;
  replay_rec_t              replay_q [$];

  function automatic int slot(int logical);
    return (head + logical) % DEPTH_DEF;
  endfunction

  // stable insertion sort of the logical order, laid out from slot 0
  task automatic reorder_store();
    logic [SEQ_BITS-1:0]      s [DEPTH_DEF];
    logic [PORT_PAY_BITS-1:0] p [DEPTH_DEF];
    logic [SEQ_BITS-1:0]      ks;
    logic [PORT_PAY_BITS-1:0] kp;
    int                       j;
    for (int i = 0; i < count; i++) begin
      s[i] = seq_mem[slot(i)];
      p[i] = pay_mem[slot(i)];
    end
    for (int i = 1; i < count; i++) begin
      ks = s[i];
      kp = p[i];
      j = i;
      while (j > 0 && s[j-1] > ks) begin
        s[j] = s[j-1];
        p[j] = p[j-1];
        j--;
      end
      s[j] = ks;
      p[j] = kp;
    end
    for (int i = 0; i < count; i++) begin
      seq_mem[i] = s[i];
      pay_mem[i] = p[i];
    end
    head = 0;
  endtask

  task automatic apply_item(logic op, logic [SEQ_BITS-1:0] sn,
                            logic [PORT_PAY_BITS-1:0] pv, logic [LIMIT_BITS-1:0] lim);
    replay_rec_t r;
    int          first;
    int          n;
    int          cap;
    if (op == OPC_APPEND) begin
      if (count > 0 && sn < seq_mem[slot(count-1)]) unsorted = 1;
      if (count < DEPTH_DEF) begin
        seq_mem[slot(count)] = sn;
        pay_mem[slot(count)] = pv;
        count++;
      end else begin
        seq_mem[head] = sn;
        pay_mem[head] = pv;
        head = (head + 1) % DEPTH_DEF;
      end
    end else begin
      queries_seen++;
      if (unsorted) begin
        reorder_store();
        unsorted = 0;
      end
      r = '0;
      r.empty = (count == 0);
      r.lo = '1;
      r.hi = '1;
      if (count > 0) begin
        r.lo = seq_mem[slot(0)];
        r.hi = seq_mem[slot(count-1)];
      end
      cap = (lim > MAX_RESULTS) ? MAX_RESULTS : int'(lim);
      if (count == 0 || cap == 0 || sn < r.lo || sn > r.hi) begin
        r.last = 1;
        replay_q = {replay_q, r};
      end else begin
        first = 0;
        while (first < count && seq_mem[slot(first)] < sn) first++;
        n = count - first;
        if (n > cap) n = cap;
        for (int i = 0; i < n; i++) begin
          r.found = 1;
          r.seq   = seq_mem[slot(first+i)];
          r.pay   = pay_mem[slot(first+i)];
          r.last  = (i + 1 == n);
          replay_q = {replay_q, r};
        end
      end
    end
  endtask

  task automatic check_field(string name, logic [SEQ_BITS-1:0] want, logic [SEQ_BITS-1:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    replay_rec_t want;
    if (rst) begin
      head     = 0;
      count    = 0;
      unsorted = 0;
      replay_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        records_seen++;
        if (replay_q.size() == 0) begin
          $display("%0t unexpected transfer expected none actual seq %h found %b",
                   $time, out_seq_number, found);
          fail_count++;
        end else begin
          want = replay_q.pop_front();
          check_field("found", want.found, found);
          check_field("out_seq_number", want.seq, out_seq_number);
          check_field("out_payload", want.pay, out_payload);
          check_field("last", want.last, last);
          check_field("store_empty", want.empty, store_empty);
          check_field("lowest_seq", want.lo, lowest_seq);
          check_field("highest_seq", want.hi, highest_seq);
        end
      end
      if (in_valid && in_ready) apply_item(opcode, seq_number, payload, limit);
    end
    records_pending = replay_q.size();
  end

  initial begin
    fail_count      = 0;
    records_pending = 0;
    records_seen    = 0;
    queries_seen    = 0;
  end

endmodule

// ===== tb/sequenced_replay_buffer_top_test.sv =====
// sequenced_replay_buffer_top_test: stimulus and verdict for the sequenced
// replay buffer; depends on srb_pkg, srb_checker and the block itself
`timescale 1ns / 1ps
module sequenced_replay_buffer_top_test;
  import srb_pkg::*;

  logic                     clk = 0;
  logic                     rst = 1;
  logic                     in_valid = 0;
  logic                     in_ready;
  logic                     opcode = OPC_APPEND;
  logic [SEQ_BITS-1:0]      seq_number = '0;
  logic [PORT_PAY_BITS-1:0] payload = '0;
  logic [LIMIT_BITS-1:0]    limit = '0;
  logic                     out_valid;
  logic                     out_ready = 0;
  logic                     found;
  logic [SEQ_BITS-1:0]      out_seq_number;
  logic [PORT_PAY_BITS-1:0] out_payload;
  logic                     last;
  logic                     store_empty;
  logic [SEQ_BITS-1:0]      lowest_seq;
  logic [SEQ_BITS-1:0]      highest_seq;

  int fail_count;
  int records_pending;
  int records_seen;
  int queries_seen;
  int items_sent = 0;

  // idle percentages of the current phase, per side
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  // numbers appended recently, so queries mostly land inside the stored range
  logic [SEQ_BITS-1:0] recent_seq [$];
  logic [SEQ_BITS-1:0] seq_cursor;

  always #2 clk = ~clk;

  sequenced_replay_buffer_top u_dut (
    .clk, .rst, .in_valid, .in_ready, .opcode, .seq_number, .payload, .limit,
    .out_valid, .out_ready, .found, .out_seq_number, .out_payload, .last,
    .store_empty, .lowest_seq, .highest_seq
  );

  srb_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .opcode, .seq_number, .payload, .limit,
    .out_valid, .out_ready, .found, .out_seq_number, .out_payload, .last,
    .store_empty, .lowest_seq, .highest_seq,
    .fail_count, .records_pending, .records_seen, .queries_seen
  );

  // receiver backpressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one transfer on the input channel; valid stays up between back-to-back items
  task automatic send_item(logic op, logic [SEQ_BITS-1:0] sn,
                           logic [PORT_PAY_BITS-1:0] pv, logic [LIMIT_BITS-1:0] lim);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid   <= 1;
    opcode     <= op;
    seq_number <= sn;
    payload    <= pv;
    limit      <= lim;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (op == OPC_APPEND) begin
      recent_seq = {recent_seq, sn};
      if (recent_seq.size() > 40) void'(recent_seq.pop_front());
    end
  endtask

  // hold off the sender until every predicted record has been delivered
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (records_pending != 0) @(posedge clk);
  endtask

  task automatic random_item();
    logic [SEQ_BITS-1:0]   qs;
    logic [LIMIT_BITS-1:0] lim;
    int                    pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      // mostly ascending with ties, some out-of-order steps and rare jumps
      pick = $urandom_range(99);
      if (pick < 78)      seq_cursor = seq_cursor + $urandom_range(0, 5);
      else if (pick < 95) seq_cursor = seq_cursor - $urandom_range(1, 20);
      else                seq_cursor = {$urandom, $urandom};
      send_item(OPC_APPEND, seq_cursor, $urandom, LIMIT_BITS'($urandom));
    end else begin
      pick = $urandom_range(99);
      if (pick < 70 && recent_seq.size() > 0)
        qs = recent_seq[$urandom_range(recent_seq.size()-1)] + $urandom_range(0, 2) - 1;
      else if (pick < 85)
        qs = seq_cursor + $urandom_range(0, 40) - 20;
      else
        qs = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 70)      lim = LIMIT_BITS'($urandom_range(1, 6));
      else if (pick < 85) lim = LIMIT_BITS'($urandom_range(0, 63));
      else                lim = LIMIT_BITS'($urandom_range(30, 40));
      send_item(OPC_QUERY, qs, $urandom, lim);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty store, range edges, zero and oversized limit, ties,
    // out-of-order appends and extreme field values
    send_item(OPC_QUERY, '0, '0, 6'd1);
    send_item(OPC_APPEND, 64'd10, 32'h0000_0000, '0);
    send_item(OPC_APPEND, 64'd20, 32'hffff_ffff, '1);
    send_item(OPC_QUERY, 64'd5, '0, 6'd4);
    send_item(OPC_QUERY, 64'd25, '0, 6'd4);
    send_item(OPC_QUERY, 64'd10, '0, 6'd0);
    send_item(OPC_QUERY, 64'd10, '1, 6'd63);
    send_item(OPC_APPEND, 64'd15, 32'h1111_1111, '0);
    send_item(OPC_APPEND, 64'd15, 32'h2222_2222, '0);
    send_item(OPC_APPEND, 64'd10, 32'h3333_3333, '0);
    send_item(OPC_QUERY, 64'd11, '0, 6'd2);
    send_item(OPC_QUERY, 64'd10, '0, 6'd32);
    send_item(OPC_QUERY, 64'd20, '0, 6'd33);
    send_item(OPC_APPEND, '1, 32'h5a5a_a5a5, '0);
    send_item(OPC_APPEND, '0, 32'ha5a5_5a5a, '0);
    send_item(OPC_QUERY, '1, '0, 6'd1);
    send_item(OPC_QUERY, '0, '0, 6'd63);
    send_item(OPC_QUERY, 64'hffff_ffff_ffff_fffe, '0, 6'd3);
    drain();

    // random phases: no idling, sender idle, receiver stall, both lightly
    seq_cursor = {$urandom, $urandom};
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = (ph == 1) ? 84 : (ph == 3) ? 10 : 0;
      recv_stall_pct  = (ph == 2) ? 84 : (ph == 3) ? 10 : 0;
      for (int i = 0; i < 76; i++) random_item();
      drain();
    end

    in_valid <= 0;
    repeat (200) @(posedge clk);
    $display("ran %0d items, %0d queries, %0d result transfers checked",
             items_sent, queries_seen, records_seen);
    $display("phases: directed edges, then random with no idle, sender idle, stall, mixed");
    if (fail_count == 0 && records_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #40000000;
    $display("timeout with %0d records outstanding", records_pending);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sequenced_replay_buffer_top.f =====
design/srb_pkg.sv
design/srb_ram.sv
design/srb_cmp.sv
design/sequenced_replay_buffer_top.sv
tb/srb_checker.sv
tb/sequenced_replay_buffer_top_test.sv
